>>> rtl/cbct_pkg.sv
// Shared types, constants and helper functions for the color blob centroid tracker.
// Used by the divider, the controller, the datapath and the top level.
package cbct_pkg;

   localparam int unsigned NUM_CLASSES = 6;
   localparam int unsigned COUNT_W     = 21;
   localparam int unsigned SUM_W       = 30;
   localparam int unsigned CENT_W      = 14;
   localparam int unsigned CFG_DATA_W  = 11;
   localparam int unsigned CFG_IDX_W   = 3;
   localparam int unsigned QUO_W       = SUM_W + 4;

   localparam logic [2:0] CLS_YELLOW = 3'd0;
   localparam logic [2:0] CLS_RED    = 3'd1;
   localparam logic [2:0] CLS_GREEN  = 3'd2;
   localparam logic [2:0] CLS_BLUE   = 3'd3;
   localparam logic [2:0] CLS_GREY   = 3'd4;
   localparam logic [2:0] CLS_WHITE  = 3'd5;
   localparam logic [2:0] CLS_NONE   = 3'd6;

   localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_FOV_X  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_FOV_Y  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PIXEL,
      ST_SCAN,
      ST_DIVIDE,
      ST_RECORD
   } ctrl_state_type;

   typedef struct packed {
      logic         pix_load;
      logic         pix_emit;
      logic         rec_emit;
      logic         div_start;
      logic         clear_all;
      logic         last;
      logic [2:0]   cls_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic                   div_done;
      logic [NUM_CLASSES-1:0] nonzero;
      logic                   frame_end;
      logic                   pix_hit;
   } dp_status_type;

   typedef struct packed {
      logic               record_kind;
      logic [7:0]         red_out;
      logic [7:0]         green_out;
      logic [7:0]         blue_out;
      logic [2:0]         target_colour;
      logic [CENT_W-1:0]  centroid_x;
      logic [CENT_W-1:0]  centroid_y;
      logic [COUNT_W-1:0] pixel_count;
      logic               last_record;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  pixel_x;
      logic [9:0]  pixel_y;
      logic [7:0]  red_in;
      logic [7:0]  green_in;
      logic [7:0]  blue_in;
      logic [23:0] right_rgb;
      logic [23:0] left_rgb;
      logic [23:0] below_rgb;
      logic [23:0] above_rgb;
      logic        frame_end;
   } req_type;

   function automatic logic is_yellow(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return ({1'b0, r} > ({1'b0, g} + 9'd20) || r == 8'd255) && g > 8'd180
         && b > 8'd0 && b < 8'd108;
   endfunction

   function automatic logic is_white(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return r >= 8'd253 && g >= 8'd253 && b >= 8'd253;
   endfunction

   // ratio a/c within [lo/100, hi/100] by cross multiplication
   function automatic logic ratio_ok(logic [7:0] a, logic [7:0] c, logic [7:0] lo,
                                     logic [7:0] hi);
      logic [15:0] lhs;
      logic [15:0] plo;
      logic [15:0] phi;
      lhs = 16'(a) * 16'd100;
      plo = 16'(c) * 16'(lo);
      phi = 16'(c) * 16'(hi);
      return lhs >= plo && lhs <= phi;
   endfunction

   function automatic logic is_green(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return g >= 8'd80 && ratio_ok(r, g, 8'd60, 8'd92) && ratio_ok(b, g, 8'd40, 8'd58);
   endfunction

   function automatic logic is_red(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return {1'b0, r} > ({1'b0, b} + 9'd80) && {1'b0, r} > ({1'b0, g} + 9'd80)
         && r > 8'd100;
   endfunction

   function automatic logic is_blue(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return b >= 8'd70 && ratio_ok(r, b, 8'd70, 8'd97) && ratio_ok(g, b, 8'd109, 8'd137);
   endfunction

   function automatic logic is_grey_nb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return b > 8'd0 && ratio_ok(r, b, 8'd96, 8'd125) && ratio_ok(g, b, 8'd102, 8'd137);
   endfunction

   function automatic logic is_grey_ctr(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return r > 8'd105 && r < 8'd118 && g > 8'd110 && g < 8'd128 && b > 8'd90
         && b < 8'd120 && ratio_ok(r, b, 8'd90, 8'd125) && ratio_ok(g, b, 8'd102, 8'd137);
   endfunction

   function automatic logic [23:0] mark_rgb(logic [2:0] cls);
      case (cls)
         CLS_YELLOW: return 24'hFFFF00;
         CLS_RED:    return 24'hFF0000;
         CLS_GREEN:  return 24'h00FF00;
         CLS_BLUE:   return 24'h0000FF;
         CLS_GREY:   return 24'h999999;
         default:    return 24'h808080;
      endcase
   endfunction

   // floor(sqrt(v)) for v <= 1024, as a threshold search
   function automatic logic [5:0] isqrt_small(logic [10:0] v);
      logic [5:0] s;
      s = 6'd0;
      for (int k = 1; k <= 32; k++) begin
         if (32'(v) >= 32'(k * k)) s = 6'(k);
      end
      return s;
   endfunction

   function automatic logic [7:0] sat255(logic [8:0] v);
      return v[8] ? 8'd255 : v[7:0];
   endfunction

endpackage

>>> rtl/cbct_stream_if.sv
// Valid/ready channel carrying one payload struct.
// The payload type is a parameter; the interface itself depends on no package.
interface cbct_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/cbct_divider.sv
// Restoring divider, one quotient bit per cycle, for centroid means.
// Depends on cbct_pkg for widths.
module cbct_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cbct_pkg::QUO_W-1:0]     dividend,
   input  logic [cbct_pkg::COUNT_W-1:0]   divisor,
   output logic                           done,
   output logic [cbct_pkg::QUO_W-1:0]     quotient
);
   localparam int unsigned CNT_W = $clog2(cbct_pkg::QUO_W + 1);

   logic [cbct_pkg::QUO_W-1:0]   quo_ff, quo_in;
   logic [cbct_pkg::COUNT_W:0]   rem_ff, rem_in;
   logic [cbct_pkg::COUNT_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [cbct_pkg::COUNT_W+1:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(cbct_pkg::QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[cbct_pkg::QUO_W-1]} - {2'b00, dsr_ff};
         if (!trial[cbct_pkg::COUNT_W+1]) begin
            rem_in = trial[cbct_pkg::COUNT_W:0];
            quo_in = {quo_ff[cbct_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[cbct_pkg::COUNT_W-1:0], quo_ff[cbct_pkg::QUO_W-1]};
            quo_in = {quo_ff[cbct_pkg::QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider did not start");
   a_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0 || $past(start) == 1'b0) else $error("divider count");
endmodule

>>> rtl/cbct_datapath.sv
// Datapath: classification, shading, per-class accumulators, centroid division.
// Depends on cbct_pkg and cbct_divider.
module cbct_datapath #(
   parameter int unsigned MAX_WIDTH  = 1024,
   parameter int unsigned MAX_HEIGHT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cbct_pkg::ctrl_cmd_type          cmd,
   output cbct_pkg::dp_status_type         status,
   input  cbct_pkg::req_type               req_data,
   input  logic                            csr_write_enable,
   input  logic [cbct_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [cbct_pkg::CFG_DATA_W-1:0] csr_write_data,
   output cbct_pkg::rsp_type               rsp_data
);
   localparam int unsigned NC = cbct_pkg::NUM_CLASSES;
   localparam int unsigned DIM_W = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT)) + 1;

   logic [5:0]  en_ff;
   logic [10:0] fw_ff, fh_ff;
   logic [9:0]  fx_ff, fy_ff;

   logic [cbct_pkg::COUNT_W-1:0] cnt_ff [NC];
   logic [cbct_pkg::SUM_W-1:0]   xs_ff  [NC];
   logic [cbct_pkg::SUM_W-1:0]   ys_ff  [NC];

   logic [2:0]  cls_ff, cls_in;
   logic [7:0]  r_ff, g_ff, b_ff;
   logic [9:0]  x_ff, y_ff;
   logic        fend_ff;
   logic        pix_done_ff;
   logic [cbct_pkg::QUO_W-1:0] qx_ff;
   logic        phase_ff;
   logic        div_done;
   logic [cbct_pkg::QUO_W-1:0] quotient;
   logic        div_go;
   logic [cbct_pkg::QUO_W-1:0] dividend;
   cbct_pkg::rsp_type rsp_ff, rsp_in;

   logic [DIM_W-1:0] w_sat, h_sat;
   logic [3:0]       present;
   logic [7:0]       nr [4], ng [4], nbb [4];
   logic [NC-1:0]    hit;
   logic [5:0]       all_y, all_w, all_r, sk_g, sk_b, sk_gr;
   logic [10:0]      dxa, dya;
   logic [21:0]      d2;
   logic [5:0]       sq;
   logic [7:0]       rr, gg, bb;
   logic [23:0]      mk;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 6'd13;
         fw_ff <= 11'd320;
         fh_ff <= 11'd240;
         fx_ff <= 10'd160;
         fy_ff <= 10'd120;
      end else if (csr_write_enable) begin
         case (csr_index)
            cbct_pkg::REG_ENABLE: en_ff <= csr_write_data[5:0];
            cbct_pkg::REG_WIDTH:  fw_ff <= csr_write_data;
            cbct_pkg::REG_HEIGHT: fh_ff <= csr_write_data;
            cbct_pkg::REG_FOV_X:  fx_ff <= csr_write_data[9:0];
            cbct_pkg::REG_FOV_Y:  fy_ff <= csr_write_data[9:0];
            default: ;
         endcase
      end
   end

   // classification of the incoming request
   always_comb begin
      w_sat = (32'(fw_ff) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : DIM_W'(fw_ff);
      h_sat = (32'(fh_ff) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_W'(fh_ff);
      present[0] = (DIM_W'(req_data.pixel_x) + DIM_W'(1)) < w_sat;
      present[1] = req_data.pixel_x != 10'd0;
      present[2] = (DIM_W'(req_data.pixel_y) + DIM_W'(1)) < h_sat;
      present[3] = req_data.pixel_y != 10'd0;
      {nr[0], ng[0], nbb[0]} = req_data.right_rgb;
      {nr[1], ng[1], nbb[1]} = req_data.left_rgb;
      {nr[2], ng[2], nbb[2]} = req_data.below_rgb;
      {nr[3], ng[3], nbb[3]} = req_data.above_rgb;
      all_y = '1; all_w = '1; all_r = '1; sk_g = '1; sk_b = '1; sk_gr = '1;
      for (int i = 0; i < 4; i++) begin
         all_y[i] = present[i] && cbct_pkg::is_yellow(nr[i], ng[i], nbb[i]);
         all_w[i] = present[i] && cbct_pkg::is_white(nr[i], ng[i], nbb[i]);
         all_r[i] = present[i] && cbct_pkg::is_red(nr[i], ng[i], nbb[i]);
         sk_g[i]  = !present[i] || cbct_pkg::is_green(nr[i], ng[i], nbb[i]);
         sk_b[i]  = !present[i] || cbct_pkg::is_blue(nr[i], ng[i], nbb[i]);
         sk_gr[i] = !present[i] || cbct_pkg::is_grey_nb(nr[i], ng[i], nbb[i]);
      end
      hit[cbct_pkg::CLS_YELLOW] = en_ff[0] && (&all_y) && req_data.red_in > 8'd230
         && cbct_pkg::is_yellow(req_data.red_in, req_data.green_in, req_data.blue_in);
      hit[cbct_pkg::CLS_RED]    = en_ff[1] && (&all_r)
         && cbct_pkg::is_red(req_data.red_in, req_data.green_in, req_data.blue_in);
      hit[cbct_pkg::CLS_GREEN]  = en_ff[2] && (&sk_g)
         && cbct_pkg::is_green(req_data.red_in, req_data.green_in, req_data.blue_in);
      hit[cbct_pkg::CLS_BLUE]   = en_ff[3] && (&sk_b)
         && cbct_pkg::is_blue(req_data.red_in, req_data.green_in, req_data.blue_in);
      hit[cbct_pkg::CLS_GREY]   = en_ff[4] && (&sk_gr)
         && cbct_pkg::is_grey_ctr(req_data.red_in, req_data.green_in, req_data.blue_in);
      hit[cbct_pkg::CLS_WHITE]  = en_ff[5] && (&all_w)
         && cbct_pkg::is_white(req_data.red_in, req_data.green_in, req_data.blue_in);
      if (req_data.pixel_y == 10'd0)           cls_in = cbct_pkg::CLS_NONE;
      else if (hit[cbct_pkg::CLS_YELLOW])      cls_in = cbct_pkg::CLS_YELLOW;
      else if (hit[cbct_pkg::CLS_WHITE])       cls_in = cbct_pkg::CLS_WHITE;
      else if (hit[cbct_pkg::CLS_GREEN])       cls_in = cbct_pkg::CLS_GREEN;
      else if (hit[cbct_pkg::CLS_RED])         cls_in = cbct_pkg::CLS_RED;
      else if (hit[cbct_pkg::CLS_BLUE])        cls_in = cbct_pkg::CLS_BLUE;
      else if (hit[cbct_pkg::CLS_GREY])        cls_in = cbct_pkg::CLS_GREY;
      else                                     cls_in = cbct_pkg::CLS_NONE;
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_load) begin
         cls_ff  <= cls_in;
         r_ff    <= req_data.red_in;
         g_ff    <= req_data.green_in;
         b_ff    <= req_data.blue_in;
         x_ff    <= req_data.pixel_x;
         y_ff    <= req_data.pixel_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fend_ff     <= 1'b0;
         pix_done_ff <= 1'b0;
      end else begin
         if (cmd.pix_load) fend_ff <= req_data.frame_end;
         pix_done_ff <= cmd.pix_load;
      end
   end

   // accumulation in the cycle after the request is taken
   always_ff @(posedge clock) begin
      for (int i = 0; i < NC; i++) begin
         if (reset || cmd.clear_all) begin
            cnt_ff[i] <= '0;
            xs_ff[i]  <= '0;
            ys_ff[i]  <= '0;
         end else if (pix_done_ff && cls_ff == 3'(i) && cnt_ff[i] != '1) begin
            cnt_ff[i] <= cnt_ff[i] + cbct_pkg::COUNT_W'(1);
            xs_ff[i]  <= ((31'(xs_ff[i]) + 31'(x_ff)) > 31'({cbct_pkg::SUM_W{1'b1}}))
                         ? '1 : cbct_pkg::SUM_W'(31'(xs_ff[i]) + 31'(x_ff));
            ys_ff[i]  <= ((31'(ys_ff[i]) + 31'(y_ff)) > 31'({cbct_pkg::SUM_W{1'b1}}))
                         ? '1 : cbct_pkg::SUM_W'(31'(ys_ff[i]) + 31'(y_ff));
         end
      end
   end

   // marking and fovea shading
   always_comb begin
      mk  = cbct_pkg::mark_rgb(cls_ff);
      dxa = (x_ff >= fx_ff) ? 11'(x_ff - fx_ff) : 11'(fx_ff - x_ff);
      dya = (y_ff >= fy_ff) ? 11'(y_ff - fy_ff) : 11'(fy_ff - y_ff);
      d2  = 22'(21'(dxa) * 21'(dxa)) + 22'(21'(dya) * 21'(dya));
      sq  = cbct_pkg::isqrt_small(d2 > 22'd1024 ? 11'd1024 : d2[10:0]);
      if (cls_ff != cbct_pkg::CLS_NONE) {rr, gg, bb} = mk;
      else {rr, gg, bb} = {r_ff, g_ff, b_ff};
      if (d2 <= 22'd256) begin
         gg = cbct_pkg::sat255(9'(gg) + 9'({sq, 1'b0}));
         bb = cbct_pkg::sat255(9'(bb) + 9'({sq, 1'b0}));
      end else if (d2 <= 22'd1024) begin
         bb = cbct_pkg::sat255(9'(bb) + 9'(sq));
      end
   end

   // centroid division, x then y
   assign div_go   = cmd.div_start || (div_done && !phase_ff);
   assign dividend = phase_ff || (div_done && !phase_ff)
                     ? {ys_ff[cmd.cls_sel], 4'b0000} : {xs_ff[cmd.cls_sel], 4'b0000};

   cbct_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (dividend),
      .divisor  (cnt_ff[cmd.cls_sel]),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset || cmd.div_start) phase_ff <= 1'b0;
      else if (div_done) phase_ff <= !phase_ff;
      if (div_done && !phase_ff) qx_ff <= quotient;
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.pix_emit) begin
         rsp_in = '0;
         rsp_in.red_out     = rr;
         rsp_in.green_out   = gg;
         rsp_in.blue_out    = bb;
         rsp_in.last_record = cmd.last;
      end else if (cmd.rec_emit) begin
         rsp_in = '0;
         rsp_in.record_kind   = 1'b1;
         rsp_in.target_colour = cmd.cls_sel;
         rsp_in.centroid_x    = (qx_ff > cbct_pkg::QUO_W'(16383)) ? '1
                                : cbct_pkg::CENT_W'(qx_ff);
         rsp_in.centroid_y    = (quotient > cbct_pkg::QUO_W'(16383)) ? '1
                                : cbct_pkg::CENT_W'(quotient);
         rsp_in.pixel_count   = cnt_ff[cmd.cls_sel];
         rsp_in.last_record   = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_comb begin
      status.div_done  = div_done && phase_ff;
      status.frame_end = fend_ff;
      status.pix_hit   = pix_done_ff && cls_ff != cbct_pkg::CLS_NONE;
      for (int i = 0; i < NC; i++) status.nonzero[i] = cnt_ff[i] != '0;
   end

   assign rsp_data = rsp_ff;

   a_no_emit_both: assert property (@(posedge clock) disable iff (reset)
      !(cmd.pix_emit && cmd.rec_emit)) else $error("two emits at once");
   a_clear_after: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_all |=> status.nonzero == '0) else $error("clear failed");
   a_rec_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.rec_emit |-> status.nonzero[cmd.cls_sel]) else $error("empty class record");
endmodule

>>> rtl/cbct_controller.sv
// Controller: sequences pixel output, per-class centroid divisions and records.
// Depends on cbct_pkg.
module cbct_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  cbct_pkg::dp_status_type  status,
   output cbct_pkg::ctrl_cmd_type   cmd
);
   cbct_pkg::ctrl_state_type state_ff, state_in;
   logic [2:0] cls_ff, cls_in;
   logic       vld_ff, vld_in;
   logic [2:0] nxt;
   logic       more;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbct_pkg::ST_IDLE;
         cls_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cls_ff   <= cls_in;
         vld_ff   <= vld_in;
      end
   end

   // next nonempty class at or after cls_ff
   always_comb begin
      nxt  = cbct_pkg::CLS_NONE;
      more = 1'b0;
      for (int i = cbct_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
         if (status.nonzero[i] && 3'(i) >= cls_ff) begin
            nxt  = 3'(i);
            more = 1'b1;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cls_in    = cls_ff;
      vld_in    = vld_ff && !rsp_ready;
      cmd       = '0;
      cmd.cls_sel = cls_ff;
      req_ready = 1'b0;
      case (state_ff)
         cbct_pkg::ST_IDLE: begin
            req_ready = !vld_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd.pix_load = 1'b1;
               state_in = cbct_pkg::ST_PIXEL;
            end
         end
         cbct_pkg::ST_PIXEL: begin
            // accumulators are updated on this edge
            cmd.pix_emit = 1'b1;
            cmd.last     = !status.frame_end || (status.nonzero == '0 && !status.pix_hit);
            vld_in       = 1'b1;
            cls_in       = '0;
            state_in     = status.frame_end ? cbct_pkg::ST_SCAN : cbct_pkg::ST_IDLE;
         end
         cbct_pkg::ST_SCAN: begin
            if (!more) begin
               if (!vld_ff || rsp_ready) begin
                  cmd.clear_all = 1'b1;
                  state_in = cbct_pkg::ST_IDLE;
               end
            end else begin
               cls_in = nxt;
               cmd.cls_sel = nxt;
               cmd.div_start = 1'b1;
               state_in = cbct_pkg::ST_DIVIDE;
            end
         end
         cbct_pkg::ST_DIVIDE: begin
            if (status.div_done) state_in = cbct_pkg::ST_RECORD;
         end
         cbct_pkg::ST_RECORD: begin
            if (!vld_ff || rsp_ready) begin
               cmd.rec_emit = 1'b1;
               vld_in = 1'b1;
               cmd.last = 1'b1;
               for (int i = 0; i < cbct_pkg::NUM_CLASSES; i++) begin
                  if (status.nonzero[i] && 3'(i) > cls_ff) cmd.last = 1'b0;
               end
               if (cmd.last) begin
                  cmd.clear_all = 1'b1;
                  state_in = cbct_pkg::ST_IDLE;
               end else begin
                  cls_in = cls_ff + 3'd1;
                  state_in = cbct_pkg::ST_SCAN;
               end
            end
         end
         default: state_in = cbct_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = vld_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == cbct_pkg::ST_IDLE) else $error("ready outside idle");
   a_pixel_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == cbct_pkg::ST_PIXEL) else $error("no pixel");
   a_emit_space: assert property (@(posedge clock) disable iff (reset)
      cmd.rec_emit |-> !vld_ff || rsp_ready) else $error("overwrite of result");
endmodule

>>> rtl/colour_blob_centroid_tracker.sv
// Color blob centroid tracker, top level: channels, configuration, instances.
// Depends on cbct_pkg, cbct_stream_if, cbct_controller and cbct_datapath.
//
// Requests arrive on req (valid/ready): one pixel with its four neighbors.
// Each request gives one pixel result on rsp, marked with the color of
// its class and fovea-shaded. A request with frame_end set is followed
// by one centroid result per nonempty class, in color code order, and
// the class accumulators then clear. last_record marks the final result
// of each request.
// A pixel result is registered from ST_PIXEL, the state after the request is
// taken; a new request is taken only back in ST_IDLE, while rsp is not stalled.
// At frame end each nonempty class takes two serial divisions of 34
// quotient bits in one shared restoring divider.
// csr writes (index 0..4) take effect at once; write only while idle.
// Reset (synchronous) loads register defaults and clears accumulators.
// While rsp stalls, the held result stays and no request is taken.
module colour_blob_centroid_tracker #(
   parameter int unsigned MAX_WIDTH  = 1024,
   parameter int unsigned MAX_HEIGHT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   cbct_stream_if.sink                     req,
   cbct_stream_if.source                   rsp,
   input  logic                            csr_write_enable,
   input  logic [cbct_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [cbct_pkg::CFG_DATA_W-1:0] csr_write_data
);
   cbct_pkg::ctrl_cmd_type  cmd;
   cbct_pkg::dp_status_type status;

   cbct_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cbct_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req.data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_data         (rsp.data)
   );
endmodule

>>> test/tb.sv
// Self-checking bench for colour_blob_centroid_tracker: a behavioral model of
// pixel classification, fovea shading and per-frame centroids checks every result.
// Depends on cbct_pkg, cbct_stream_if and the RTL under rtl/.
module tb;
   logic clock;
   logic reset;
   logic                            csr_write_enable;
   logic [cbct_pkg::CFG_IDX_W-1:0]  csr_index;
   logic [cbct_pkg::CFG_DATA_W-1:0] csr_write_data;

   cbct_stream_if #(.payload_type(cbct_pkg::req_type)) req_ch ();
   cbct_stream_if #(.payload_type(cbct_pkg::rsp_type)) rsp_ch ();

   colour_blob_centroid_tracker u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch.sink),
      .rsp              (rsp_ch.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   localparam int DIM_CAP   = 1024;
   localparam int COUNT_TOP = 2097151;
   localparam int SUM_TOP   = 1073741823;

   // shadow registers and class accumulators
   int unsigned en_mask, frame_w, frame_h, fov_x, fov_y;
   int unsigned blob_count [6];
   int unsigned blob_xsum  [6];
   int unsigned blob_ysum  [6];

   cbct_pkg::req_type pending_requests [$];
   cbct_pkg::rsp_type expected_records [$];
   int      mismatches;
   bit      hold_sender;
   int      burst_left, gap_left, cycle_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 800000);
      $display("tb: failure");
      $finish;
   end

   // ---------------- color tests ----------------
   function automatic bit hue_yellow(int r, int g, int b);
      return (r > g + 20 || r == 255) && g > 180 && b > 0 && b < 108;
   endfunction

   function automatic bit hue_white(int r, int g, int b);
      return r >= 253 && g >= 253 && b >= 253;
   endfunction

   function automatic bit hue_green(int r, int g, int b);
      return g >= 80 && 100 * r >= 60 * g && 100 * r <= 92 * g
         && 100 * b >= 40 * g && 100 * b <= 58 * g;
   endfunction

   function automatic bit hue_red(int r, int g, int b);
      return r > b + 80 && r > g + 80 && r > 100;
   endfunction

   function automatic bit hue_blue(int r, int g, int b);
      return b >= 70 && 100 * r >= 70 * b && 100 * r <= 97 * b
         && 100 * g >= 109 * b && 100 * g <= 137 * b;
   endfunction

   function automatic bit hue_grey_nb(int r, int g, int b);
      return b > 0 && 100 * r >= 96 * b && 100 * r <= 125 * b
         && 100 * g >= 102 * b && 100 * g <= 137 * b;
   endfunction

   function automatic bit hue_grey_ctr(int r, int g, int b);
      return r > 105 && r < 118 && g > 110 && g < 128 && b > 90 && b < 120
         && 100 * r >= 90 * b && 100 * r <= 125 * b
         && 100 * g >= 102 * b && 100 * g <= 137 * b;
   endfunction

   function automatic bit hue_test(logic [2:0] cls, logic [23:0] p, bit centre);
      int r, g, b;
      r = p[23:16];
      g = p[15:8];
      b = p[7:0];
      case (cls)
         cbct_pkg::CLS_YELLOW: return hue_yellow(r, g, b) && (!centre || r > 230);
         cbct_pkg::CLS_WHITE:  return hue_white(r, g, b);
         cbct_pkg::CLS_GREEN:  return hue_green(r, g, b);
         cbct_pkg::CLS_RED:    return hue_red(r, g, b);
         cbct_pkg::CLS_BLUE:   return hue_blue(r, g, b);
         default:    return centre ? hue_grey_ctr(r, g, b) : hue_grey_nb(r, g, b);
      endcase
   endfunction

   function automatic logic [23:0] class_mark(logic [2:0] cls);
      case (cls)
         cbct_pkg::CLS_YELLOW: return {8'd255, 8'd255, 8'd0};
         cbct_pkg::CLS_RED:    return {8'd255, 8'd0, 8'd0};
         cbct_pkg::CLS_GREEN:  return {8'd0, 8'd255, 8'd0};
         cbct_pkg::CLS_BLUE:   return {8'd0, 8'd0, 8'd255};
         cbct_pkg::CLS_GREY:   return {8'd153, 8'd153, 8'd153};
         default:    return {8'd128, 8'd128, 8'd128};
      endcase
   endfunction

   // ---------------- prediction ----------------
   task automatic track_pixel(input cbct_pkg::req_type q);
      logic [23:0] nbs [4];
      bit          here [4];
      logic [2:0]  order [6];
      bit          full, ok;
      int unsigned w, h, x, y, r, g, b, d2, s, cx, cy;
      int          dx, dy;
      logic [2:0]  cls;
      logic [23:0] centre;
      cbct_pkg::rsp_type rec;
      cbct_pkg::rsp_type batch [$];
      order = '{cbct_pkg::CLS_YELLOW, cbct_pkg::CLS_WHITE, cbct_pkg::CLS_GREEN,
                cbct_pkg::CLS_RED, cbct_pkg::CLS_BLUE, cbct_pkg::CLS_GREY};
      w = frame_w > DIM_CAP ? DIM_CAP : frame_w;
      h = frame_h > DIM_CAP ? DIM_CAP : frame_h;
      x = q.pixel_x;
      y = q.pixel_y;
      nbs = '{q.right_rgb, q.left_rgb, q.below_rgb, q.above_rgb};
      here = '{x + 1 < w, x > 0, y + 1 < h, y > 0};
      centre = {q.red_in, q.green_in, q.blue_in};
      cls = cbct_pkg::CLS_NONE;
      if (y != 0) begin
         foreach (order[k]) begin
            if (cls == cbct_pkg::CLS_NONE && en_mask[order[k]]
                && hue_test(order[k], centre, 1'b1)) begin
               full = order[k] inside {cbct_pkg::CLS_YELLOW, cbct_pkg::CLS_WHITE,
                                       cbct_pkg::CLS_RED};
               ok = 1'b1;
               for (int i = 0; i < 4; i++) begin
                  if (!here[i]) begin
                     if (full) ok = 1'b0;
                  end else if (!hue_test(order[k], nbs[i], 1'b0)) begin
                     ok = 1'b0;
                  end
               end
               if (ok) cls = order[k];
            end
         end
      end
      if (cls != cbct_pkg::CLS_NONE) begin
         if (blob_count[cls] < COUNT_TOP) begin
            blob_count[cls]++;
            blob_xsum[cls] = (blob_xsum[cls] + x > SUM_TOP) ? SUM_TOP : blob_xsum[cls] + x;
            blob_ysum[cls] = (blob_ysum[cls] + y > SUM_TOP) ? SUM_TOP : blob_ysum[cls] + y;
         end
         centre = class_mark(cls);
      end
      r = centre[23:16];
      g = centre[15:8];
      b = centre[7:0];
      dx = int'(x) - int'(fov_x);
      dy = int'(y) - int'(fov_y);
      d2 = dx * dx + dy * dy;
      s = 0;
      while ((s + 1) * (s + 1) <= d2 && s < 40) s++;
      if (d2 <= 256) begin
         g = (g + 2 * s > 255) ? 255 : g + 2 * s;
         b = (b + 2 * s > 255) ? 255 : b + 2 * s;
      end else if (d2 <= 1024) begin
         b = (b + s > 255) ? 255 : b + s;
      end
      rec = '0;
      rec.red_out = r[7:0];
      rec.green_out = g[7:0];
      rec.blue_out = b[7:0];
      batch.push_back(rec);
      if (q.frame_end) begin
         for (int i = 0; i < 6; i++) begin
            if (blob_count[i] != 0) begin
               longint mx, my;
               mx = (longint'(blob_xsum[i]) * 16) / blob_count[i];
               my = (longint'(blob_ysum[i]) * 16) / blob_count[i];
               rec = '0;
               rec.record_kind = 1'b1;
               rec.target_colour = 3'(i);
               rec.centroid_x = mx > 16383 ? 14'd16383 : 14'(mx);
               rec.centroid_y = my > 16383 ? 14'd16383 : 14'(my);
               rec.pixel_count = 21'(blob_count[i]);
               batch.push_back(rec);
            end
            blob_count[i] = 0;
            blob_xsum[i] = 0;
            blob_ysum[i] = 0;
         end
      end
      batch[batch.size() - 1].last_record = 1'b1;
      foreach (batch[k]) expected_records.push_back(batch[k]);
   endtask

   // ---------------- checking ----------------
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   task automatic check_record(input cbct_pkg::rsp_type got);
      cbct_pkg::rsp_type want;
      if (expected_records.size() == 0) begin
         report_mismatch("unexpected result", 1, 0);
         return;
      end
      want = expected_records.pop_front();
      if (got.record_kind != want.record_kind)
         report_mismatch("record_kind", got.record_kind, want.record_kind);
      if (got.red_out != want.red_out) report_mismatch("red_out", got.red_out, want.red_out);
      if (got.green_out != want.green_out)
         report_mismatch("green_out", got.green_out, want.green_out);
      if (got.blue_out != want.blue_out)
         report_mismatch("blue_out", got.blue_out, want.blue_out);
      if (got.target_colour != want.target_colour)
         report_mismatch("target_colour", got.target_colour, want.target_colour);
      if (got.centroid_x != want.centroid_x)
         report_mismatch("centroid_x", got.centroid_x, want.centroid_x);
      if (got.centroid_y != want.centroid_y)
         report_mismatch("centroid_y", got.centroid_y, want.centroid_y);
      if (got.pixel_count != want.pixel_count)
         report_mismatch("pixel_count", got.pixel_count, want.pixel_count);
      if (got.last_record != want.last_record)
         report_mismatch("last_record", got.last_record, want.last_record);
   endtask

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data  <= '0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) track_pixel(req_ch.data);
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (!hold_sender && pending_requests.size() > 0) begin
               req_ch.data  <= pending_requests.pop_front();
               req_ch.valid <= 1'b1;
               if (burst_left == 0) burst_left = $urandom_range(1, 30);
               burst_left--;
               if (burst_left == 0) gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 9);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         cycle_count = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_record(rsp_ch.data);
         cycle_count++;
         if (cycle_count % 300 < 80) rsp_ch.ready <= 1'b1;
         else if (cycle_count % 300 < 200) rsp_ch.ready <= $urandom_range(0, 3) != 0;
         else rsp_ch.ready <= (cycle_count % 7) < 3;
      end
   end

   // ---------------- stimulus ----------------
   task automatic set_register(input logic [cbct_pkg::CFG_IDX_W-1:0] idx,
                               input int unsigned val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val[cbct_pkg::CFG_DATA_W-1:0];
      case (idx)
         cbct_pkg::REG_ENABLE: en_mask = val & 'h3F;
         cbct_pkg::REG_WIDTH:  frame_w = val & 'h7FF;
         cbct_pkg::REG_HEIGHT: frame_h = val & 'h7FF;
         cbct_pkg::REG_FOV_X:  fov_x = val & 'h3FF;
         default:    fov_y = val & 'h3FF;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic settings(input int unsigned e, w, h, cx, cy);
      set_register(cbct_pkg::REG_ENABLE, e);
      set_register(cbct_pkg::REG_WIDTH, w);
      set_register(cbct_pkg::REG_HEIGHT, h);
      set_register(cbct_pkg::REG_FOV_X, cx);
      set_register(cbct_pkg::REG_FOV_Y, cy);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_ch.valid || expected_records.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [23:0] rgb(int r, int g, int b);
      return {8'(r), 8'(g), 8'(b)};
   endfunction

   function automatic logic [23:0] colour_of(logic [2:0] cls);
      int r, g, b;
      case (cls)
         cbct_pkg::CLS_YELLOW: begin
            r = $urandom_range(231, 255);
            g = $urandom_range(181, r - 21);
            b = $urandom_range(1, 107);
         end
         cbct_pkg::CLS_WHITE: begin
            r = $urandom_range(253, 255);
            g = $urandom_range(253, 255);
            b = $urandom_range(253, 255);
         end
         cbct_pkg::CLS_GREEN: begin
            g = $urandom_range(80, 255);
            r = $urandom_range((60 * g + 99) / 100, 92 * g / 100);
            b = $urandom_range((40 * g + 99) / 100, 58 * g / 100);
         end
         cbct_pkg::CLS_RED: begin
            r = $urandom_range(101, 255);
            g = $urandom_range(0, r - 81);
            b = $urandom_range(0, r - 81);
         end
         cbct_pkg::CLS_BLUE: begin
            b = $urandom_range(70, 233);
            r = $urandom_range((70 * b + 99) / 100, 97 * b / 100);
            g = $urandom_range((109 * b + 99) / 100, 137 * b / 100 > 255 ? 255 : 137 * b / 100);
         end
         default: begin
            do begin
               r = $urandom_range(106, 117);
               g = $urandom_range(111, 127);
               b = $urandom_range(91, 119);
            end while (!(hue_grey_ctr(r, g, b) && hue_grey_nb(r, g, b)));
         end
      endcase
      return rgb(r, g, b);
   endfunction

   function automatic cbct_pkg::req_type pixel(int x, int y, logic [23:0] c,
                                               logic [23:0] rt, lt, bl, ab, bit fend);
      cbct_pkg::req_type q;
      q.pixel_x = 10'(x);
      q.pixel_y = 10'(y);
      {q.red_in, q.green_in, q.blue_in} = c;
      q.right_rgb = rt;
      q.left_rgb = lt;
      q.below_rgb = bl;
      q.above_rgb = ab;
      q.frame_end = fend;
      return q;
   endfunction

   function automatic cbct_pkg::req_type random_pixel(bit fend);
      int unsigned w, h, x, y, kind;
      logic [2:0]  cls;
      logic [23:0] nb [4];
      logic [23:0] c;
      w = frame_w > DIM_CAP ? DIM_CAP : frame_w;
      h = frame_h > DIM_CAP ? DIM_CAP : frame_h;
      x = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, w - 1);
      y = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, h - 1);
      if ($urandom_range(0, 4) == 0) begin
         x = fov_x + $urandom_range(0, 60) - 30;
         y = fov_y + $urandom_range(0, 60) - 30;
         if (x > 1023) x = fov_x;
         if (y > 1023) y = fov_y;
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         cls = 3'($urandom_range(0, 5));
         c = colour_of(cls);
         for (int i = 0; i < 4; i++) nb[i] = colour_of(cls);
         if (kind == 6) nb[$urandom_range(0, 3)] = 24'($urandom());
      end else begin
         c = 24'($urandom());
         for (int i = 0; i < 4; i++) nb[i] = 24'($urandom());
      end
      return pixel(x, y, c, nb[0], nb[1], nb[2], nb[3], fend);
   endfunction

   task automatic random_frames(input int n_items);
      int left;
      left = n_items;
      while (left > 0) begin
         int len;
         len = $urandom_range(3, 40);
         if (len > left) len = left;
         for (int k = 0; k < len; k++) pending_requests.push_back(random_pixel(k == len - 1));
         left -= len;
      end
   endtask

   task automatic directed_items();
      logic [23:0] y0, g0, r0, b0, s0;
      y0 = rgb(250, 200, 50);
      g0 = rgb(60, 100, 50);
      r0 = rgb(200, 20, 20);
      b0 = rgb(60, 100, 80);
      s0 = rgb(112, 120, 100);
      pending_requests.push_back(pixel(20, 5, y0, y0, y0, y0, y0, 0));
      pending_requests.push_back(pixel(21, 5, 24'hFFFFFF, 24'hFDFDFD, 24'hFFFFFF, 24'hFEFEFE,
                                       24'hFFFFFF, 0));
      pending_requests.push_back(pixel(0, 6, g0, g0, 24'h000000, g0, g0, 0));
      pending_requests.push_back(pixel(22, 6, r0, r0, r0, r0, r0, 0));
      pending_requests.push_back(pixel(0, 7, r0, r0, r0, r0, r0, 0));
      pending_requests.push_back(pixel(23, 31, b0, b0, b0, 24'h123456, b0, 0));
      pending_requests.push_back(pixel(24, 7, s0, s0, s0, s0, s0, 0));
      pending_requests.push_back(pixel(25, 7, s0, s0, s0, s0, rgb(0, 0, 0), 0));
      pending_requests.push_back(pixel(26, 0, y0, y0, y0, y0, y0, 0));
      pending_requests.push_back(pixel(10, 10, rgb(9, 255, 250), 0, 0, 0, 0, 0));
      pending_requests.push_back(pixel(13, 14, rgb(9, 250, 250), 0, 0, 0, 0, 0));
      pending_requests.push_back(pixel(30, 10, rgb(1, 2, 250), 0, 0, 0, 0, 0));
      pending_requests.push_back(pixel(1023, 1023, g0, g0, g0, g0, g0, 0));
      pending_requests.push_back(pixel(0, 0, 24'h000000, 0, 0, 0, 0, 0));
      pending_requests.push_back(pixel(1023, 1023, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                       24'hFFFFFF, 24'hFFFFFF, 0));
      pending_requests.push_back(pixel(40, 20, r0, r0, r0, r0, r0, 1));
      pending_requests.push_back(pixel(5, 5, 24'h000000, 0, 0, 0, 0, 1));
   endtask

   initial begin
      reset = 1'b1;
      hold_sender = 1'b0;
      mismatches = 0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      en_mask = 13;
      frame_w = 320;
      frame_h = 240;
      fov_x = 160;
      fov_y = 120;
      for (int i = 0; i < 6; i++) begin
         blob_count[i] = 0;
         blob_xsum[i] = 0;
         blob_ysum[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      random_frames(60);
      drain();
      settings(63, 64, 32, 10, 10);
      directed_items();
      drain();
      settings(63, 1024, 1024, 0, 0);
      random_frames(90);
      // sender holds off until the block is empty
      repeat (40) @(posedge clock);
      hold_sender = 1'b1;
      do @(negedge clock);
      while (req_ch.valid || expected_records.size() != 0);
      hold_sender = 1'b0;
      drain();
      settings(0, 3, 3, 1023, 1023);
      random_frames(40);
      drain();
      settings(63, 16, 16, 8, 8);
      random_frames(100);
      drain();
      settings($urandom_range(0, 63), $urandom_range(3, 1024), $urandom_range(3, 1024),
               $urandom_range(0, 1023), $urandom_range(0, 1023));
      random_frames(80);
      drain();
      settings(42, 1000, 3, 512, 1);
      random_frames(40);
      drain();
      settings(21, 200, 100, 100, 50);
      random_frames(50);
      drain();
      repeat (100) @(posedge clock);

      if (mismatches == 0 && expected_records.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
